/* design/ssrt_pkg.sv */
// shared codes and control types for the sorted sequence reorder table
`timescale 1ns / 1ps

package ssrt_pkg;

   localparam int SEQ_W    = 31;
   localparam int TAG_W    = 31;
   localparam int HANDLE_W = 16;
   localparam int RESULT_W = 32;

   // request opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DUP   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic evaluate;
      logic commit;
   } ssrt_cmd_type;

endpackage

/* design/sorted_sequence_reorder_table.sv */
// top level of the sorted sequence reorder table
`timescale 1ns / 1ps

// Receive reorder table holding up to TABLE_DEPTH entries (sequence number,
// base tag, buffer handle) sorted by ascending sequence number in a row of
// register cells. Opcode insert places an entry in order (a duplicate only
// rewrites the tag, a full table drops it), query returns the last sequence
// number of the in-order run at the front (or query_base-1 when the table is
// empty or the base lies below the front entry), pop removes the front entry.
// Every request gives exactly one response transfer. One request is worked on
// at a time in three steps: capture, a parallel compare of all cells,
// and a commit that shifts the cells and loads the response register. The
// next request transfer is taken the cycle after commit; commit waits while
// a previous response is still stalled in the output register.

module sorted_sequence_reorder_table import ssrt_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [SEQ_W-1:0]           req_seq_number,
   input  logic [TAG_W-1:0]           req_base_tag,
   input  logic [HANDLE_W-1:0]        req_buffer_handle,
   input  logic [SEQ_W-1:0]           req_query_base,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RESULT_W-1:0] rsp_result_seq,
   output logic [1:0]                 rsp_status,
   output logic [TAG_W-1:0]           rsp_out_tag,
   output logic [HANDLE_W-1:0]        rsp_out_handle
);

   ssrt_cmd_type cmd;

   // sequencing: idle, compare, commit
   ssrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // cells, flags and response register
   ssrt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_seq_number    (req_seq_number),
      .req_base_tag      (req_base_tag),
      .req_buffer_handle (req_buffer_handle),
      .req_query_base    (req_query_base),
      .rsp_result_seq    (rsp_result_seq),
      .rsp_status        (rsp_status),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_handle    (rsp_out_handle)
   );

endmodule

/* design/ssrt_ctrl.sv */
// controller state machine for the sorted sequence reorder table
`timescale 1ns / 1ps

module ssrt_ctrl import ssrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ssrt_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EVAL   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_busy;

   assign out_busy     = rsp_valid_ff && rsp_stall;
   assign req_stall    = (state_ff != S_IDLE);
   assign cmd.capture  = req_valid && (state_ff == S_IDLE);
   assign cmd.evaluate = (state_ff == S_EVAL);
   assign cmd.commit   = (state_ff == S_COMMIT) && !out_busy;
   assign rsp_valid    = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!out_busy) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/ssrt_datapath.sv */
// sorted cell row, compare flags and response register
`timescale 1ns / 1ps

module ssrt_datapath import ssrt_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ssrt_cmd_type               cmd,
   input  logic [1:0]                 req_opcode,
   input  logic [SEQ_W-1:0]           req_seq_number,
   input  logic [TAG_W-1:0]           req_base_tag,
   input  logic [HANDLE_W-1:0]        req_buffer_handle,
   input  logic [SEQ_W-1:0]           req_query_base,
   output logic signed [RESULT_W-1:0] rsp_result_seq,
   output logic [1:0]                 rsp_status,
   output logic [TAG_W-1:0]           rsp_out_tag,
   output logic [HANDLE_W-1:0]        rsp_out_handle
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int D  = TABLE_DEPTH;

   // latched request
   logic [1:0]          op_ff;
   logic [SEQ_W-1:0]    seq_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [SEQ_W-1:0]    base_ff;

   // sorted cells
   logic [SEQ_W-1:0]    cell_seq_ff    [D];
   logic [TAG_W-1:0]    cell_tag_ff    [D];
   logic [HANDLE_W-1:0] cell_handle_ff [D];
   logic [SEQ_W-1:0]    cell_seq_in    [D];
   logic [TAG_W-1:0]    cell_tag_in    [D];
   logic [HANDLE_W-1:0] cell_handle_in [D];
   logic [CW-1:0]       count_ff, count_in;

   // per-cell compare flags
   logic [D-1:0] lt_ff, eq_ff, brk_ff;
   logic [D-1:0] lt_in, eq_in, brk_in;
   logic [D-1:0] lt_prev;
   logic         below_ff, below_in;

   // response register
   logic [RESULT_W-1:0] res_seq_ff, res_seq_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic [TAG_W-1:0]    res_tag_ff, res_tag_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;

   logic                empty, full, dup, found;
   logic [SEQ_W-1:0]    run_end;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(D));
   assign dup     = |eq_ff;
   assign lt_prev = {lt_ff[D-2:0], 1'b1};

   // compare stage
   always_comb begin
      for (int i = 0; i < D; i++) begin
         lt_in[i] = (CW'(i) < count_ff) && (cell_seq_ff[i] < seq_ff);
         eq_in[i] = (CW'(i) < count_ff) && (cell_seq_ff[i] == seq_ff);
      end
      for (int i = 0; i < D - 1; i++) begin
         brk_in[i] = !(CW'(i + 1) < count_ff) ||
                     (({1'b0, cell_seq_ff[i]} + 32'd1) != {1'b0, cell_seq_ff[i + 1]});
      end
      brk_in[D-1] = 1'b1;
      below_in    = base_ff < cell_seq_ff[0];
   end

   // end of the run starting at the front cell
   always_comb begin
      found   = 1'b0;
      run_end = '0;
      for (int i = 0; i < D; i++) begin
         if (brk_ff[i] && !found) begin
            run_end = cell_seq_ff[i];
            found   = 1'b1;
         end
      end
   end

   // commit stage
   always_comb begin
      for (int i = 0; i < D; i++) begin
         cell_seq_in[i]    = cell_seq_ff[i];
         cell_tag_in[i]    = cell_tag_ff[i];
         cell_handle_in[i] = cell_handle_ff[i];
      end
      count_in      = count_ff;
      res_seq_in    = '0;
      res_status_in = ST_OK;
      res_tag_in    = '0;
      res_handle_in = '0;
      unique case (op_ff)
         OP_INSERT: begin
            if (dup) begin
               res_status_in = ST_DUP;
               for (int i = 0; i < D; i++) begin
                  if (eq_ff[i]) cell_tag_in[i] = tag_ff;
               end
            end else if (full) begin
               res_status_in = ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
               for (int i = 0; i < D; i++) begin
                  if (!lt_ff[i] && lt_prev[i]) begin
                     cell_seq_in[i]    = seq_ff;
                     cell_tag_in[i]    = tag_ff;
                     cell_handle_in[i] = handle_ff;
                  end
               end
               for (int i = 1; i < D; i++) begin
                  if (!lt_ff[i] && !lt_prev[i]) begin
                     cell_seq_in[i]    = cell_seq_ff[i - 1];
                     cell_tag_in[i]    = cell_tag_ff[i - 1];
                     cell_handle_in[i] = cell_handle_ff[i - 1];
                  end
               end
            end
         end
         OP_QUERY: begin
            if (empty || below_ff) res_seq_in = {1'b0, base_ff} - 32'd1;
            else                   res_seq_in = {1'b0, run_end};
         end
         OP_POP: begin
            if (empty) begin
               res_status_in = ST_EMPTY;
            end else begin
               res_seq_in    = {1'b0, cell_seq_ff[0]};
               res_tag_in    = cell_tag_ff[0];
               res_handle_in = cell_handle_ff[0];
               count_in      = count_ff - CW'(1);
               for (int i = 0; i < D - 1; i++) begin
                  cell_seq_in[i]    = cell_seq_ff[i + 1];
                  cell_tag_in[i]    = cell_tag_ff[i + 1];
                  cell_handle_in[i] = cell_handle_ff[i + 1];
               end
            end
         end
         OP_NONE: begin
            res_status_in = ST_OK;
         end
         default: begin
            res_status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_opcode;
         seq_ff    <= req_seq_number;
         tag_ff    <= req_base_tag;
         handle_ff <= req_buffer_handle;
         base_ff   <= req_query_base;
      end
      if (cmd.evaluate) begin
         lt_ff    <= lt_in;
         eq_ff    <= eq_in;
         brk_ff   <= brk_in;
         below_ff <= below_in;
      end
      if (cmd.commit) begin
         for (int i = 0; i < D; i++) begin
            cell_seq_ff[i]    <= cell_seq_in[i];
            cell_tag_ff[i]    <= cell_tag_in[i];
            cell_handle_ff[i] <= cell_handle_in[i];
         end
         res_seq_ff    <= res_seq_in;
         res_status_ff <= res_status_in;
         res_tag_ff    <= res_tag_in;
         res_handle_ff <= res_handle_in;
      end
   end

   assign rsp_result_seq = $signed(res_seq_ff);
   assign rsp_status     = res_status_ff;
   assign rsp_out_tag    = res_tag_ff;
   assign rsp_out_handle = res_handle_ff;

endmodule

/* design/ssrt_checker.sv */
// port level checks for the sorted sequence reorder table
`timescale 1ns / 1ps

module ssrt_checker import ssrt_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [RESULT_W-1:0] rsp_result_seq,
   input logic [1:0]                 rsp_status,
   input logic [TAG_W-1:0]           rsp_out_tag,
   input logic [HANDLE_W-1:0]        rsp_out_handle
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_seq) &&
      $stable(rsp_status) && $stable(rsp_out_tag) && $stable(rsp_out_handle))
      else $error("stalled response changed");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // a new response only follows busy cycles
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without work");

   // empty pop gives zero fields
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
      rsp_result_seq == 0 && rsp_out_tag == '0 && rsp_out_handle == '0)
      else $error("empty pop with nonzero fields");

   // dropped insert gives zero fields
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
      rsp_result_seq == 0 && rsp_out_tag == '0 && rsp_out_handle == '0)
      else $error("dropped insert with nonzero fields");

endmodule

bind sorted_sequence_reorder_table ssrt_checker u_checker (.*);

/* tb/sv/reorder_table_checker.sv */
// response predictor and checker for the sorted sequence reorder table
`timescale 1ns / 1ps

module reorder_table_checker import ssrt_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [SEQ_W-1:0]           req_seq_number,
   input  logic [TAG_W-1:0]           req_base_tag,
   input  logic [HANDLE_W-1:0]        req_buffer_handle,
   input  logic [SEQ_W-1:0]           req_query_base,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [RESULT_W-1:0] rsp_result_seq,
   input  logic [1:0]                 rsp_status,
   input  logic [TAG_W-1:0]           rsp_out_tag,
   input  logic [HANDLE_W-1:0]        rsp_out_handle,
   output int                         mismatch_count,
   output int                         pending_responses
);

   typedef struct packed {
      logic signed [RESULT_W-1:0] result_seq;
      logic [1:0]                 status;
      logic [TAG_W-1:0]           tag;
      logic [HANDLE_W-1:0]        handle;
   } table_response_type;

   // shadow copy of the sorted table
   logic [SEQ_W-1:0]    held_seq    [TABLE_DEPTH];
   logic [TAG_W-1:0]    held_tag    [TABLE_DEPTH];
   logic [HANDLE_W-1:0] held_handle [TABLE_DEPTH];
   int                  held_count;
   table_response_type  awaited [$];

   // updates the shadow table and returns the response the request should give
   function automatic table_response_type next_table_response(
      input logic [1:0]          opcode,
      input logic [SEQ_W-1:0]    seq,
      input logic [TAG_W-1:0]    tag,
      input logic [HANDLE_W-1:0] handle,
      input logic [SEQ_W-1:0]    base
   );
      table_response_type answer;
      int                 slot;
      answer = '0;
      case (opcode)
         OP_INSERT: begin
            slot = 0;
            while (slot < held_count && held_seq[slot] < seq)
               slot++;
            if (slot < held_count && held_seq[slot] == seq) begin
               held_tag[slot] = tag;
               answer.status  = ST_DUP;
            end else if (held_count >= TABLE_DEPTH) begin
               answer.status = ST_FULL;
            end else begin
               for (int k = held_count; k > slot; k--) begin
                  held_seq[k]    = held_seq[k-1];
                  held_tag[k]    = held_tag[k-1];
                  held_handle[k] = held_handle[k-1];
               end
               held_seq[slot]    = seq;
               held_tag[slot]    = tag;
               held_handle[slot] = handle;
               held_count++;
            end
         end
         OP_QUERY: begin
            if (held_count == 0 || base < held_seq[0]) begin
               answer.result_seq = {1'b0, base} - 32'd1;
            end else begin
               answer.result_seq = {1'b0, held_seq[held_count-1]};
               for (int i = 0; i + 1 < held_count; i++) begin
                  if ({1'b0, held_seq[i]} + 32'd1 != {1'b0, held_seq[i+1]}) begin
                     answer.result_seq = {1'b0, held_seq[i]};
                     break;
                  end
               end
            end
         end
         OP_POP: begin
            if (held_count == 0) begin
               answer.status = ST_EMPTY;
            end else begin
               answer.result_seq = {1'b0, held_seq[0]};
               answer.tag        = held_tag[0];
               answer.handle     = held_handle[0];
               for (int k = 0; k + 1 < held_count; k++) begin
                  held_seq[k]    = held_seq[k+1];
                  held_tag[k]    = held_tag[k+1];
                  held_handle[k] = held_handle[k+1];
               end
               held_count--;
            end
         end
         default: ;
      endcase
      return answer;
   endfunction

   always @(posedge clock) begin : compare_responses
      table_response_type wanted;
      int                 fails_now;
      fails_now = 0;
      if (reset) begin
         held_count = 0;
         awaited.delete();
      end else begin
         if (req_valid && !req_stall)
            awaited.push_back(next_table_response(req_opcode, req_seq_number, req_base_tag,
                                                  req_buffer_handle, req_query_base));
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               $display("%0t ns: unexpected response seq %0d status %0d tag %0d handle %0d",
                        $time, rsp_result_seq, rsp_status, rsp_out_tag, rsp_out_handle);
               fails_now++;
            end else begin
               wanted = awaited.pop_front();
               if (rsp_result_seq !== wanted.result_seq) begin
                  $display("%0t ns: result_seq expected %0d got %0d",
                           $time, wanted.result_seq, rsp_result_seq);
                  fails_now++;
               end
               if (rsp_status !== wanted.status) begin
                  $display("%0t ns: status expected %0d got %0d",
                           $time, wanted.status, rsp_status);
                  fails_now++;
               end
               if (rsp_out_tag !== wanted.tag) begin
                  $display("%0t ns: out_tag expected %0d got %0d",
                           $time, wanted.tag, rsp_out_tag);
                  fails_now++;
               end
               if (rsp_out_handle !== wanted.handle) begin
                  $display("%0t ns: out_handle expected %0d got %0d",
                           $time, wanted.handle, rsp_out_handle);
                  fails_now++;
               end
            end
         end
      end
      mismatch_count    <= mismatch_count + fails_now;
      pending_responses <= awaited.size();
   end

endmodule

/* tb/sv/sorted_sequence_reorder_table_tb.sv */
// testbench top for the sorted sequence reorder table
`timescale 1ns / 1ps

module sorted_sequence_reorder_table_tb;
   import ssrt_pkg::*;

   localparam int TABLE_DEPTH    = 16;
   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 10;
   localparam int PHASE_ITEMS    = 630;   // three phases, about 1900 requests in all
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the block
   localparam int SETTLE_CYCLES  = 20;    // longer than one request's capture, compare and commit
   // longest legal quiet stretch is the hold-off plus a rare run of random stalls
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_opcode        = OP_INSERT;
   logic [SEQ_W-1:0]           req_seq_number    = '0;
   logic [TAG_W-1:0]           req_base_tag      = '0;
   logic [HANDLE_W-1:0]        req_buffer_handle = '0;
   logic [SEQ_W-1:0]           req_query_base    = '0;
   logic                       rsp_valid;
   logic                       rsp_stall         = 1'b0;
   logic signed [RESULT_W-1:0] rsp_result_seq;
   logic [1:0]                 rsp_status;
   logic [TAG_W-1:0]           rsp_out_tag;
   logic [HANDLE_W-1:0]        rsp_out_handle;

   int   mismatch_count;
   int   pending_responses;

   // idle odds in percent for each side of the block
   int   sender_idle_pct   = 0;
   int   receiver_idle_pct = 0;
   // receiver hold-off, requested once by the stimulus and counted by the receiver
   logic hold_start = 1'b0;
   logic hold_done  = 1'b0;
   int   hold_left  = 0;
   int   phase_items  = 0;
   int   quiet_cycles = 0;

   always #CLOCK_HALF clock = ~clock;

   sorted_sequence_reorder_table #(.TABLE_DEPTH(TABLE_DEPTH)) uut (.*);

   // watches both channels, keeps a shadow table and compares every response
   reorder_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) table_checker (.*);

   // full range 31 bit value for sequence numbers, tags and query bases
   function automatic logic [SEQ_W-1:0] random_seq_field();
      logic [31:0] draw;
      draw = $urandom();
      return draw[SEQ_W-1:0];
   endfunction

   // one request transfer: optional idle gap, then hold the payload until taken
   task automatic send_request(
      input logic [1:0]          opcode,
      input logic [SEQ_W-1:0]    seq,
      input logic [TAG_W-1:0]    tag,
      input logic [HANDLE_W-1:0] handle,
      input logic [SEQ_W-1:0]    base
   );
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= opcode;
      req_seq_number    <= seq;
      req_base_tag      <= tag;
      req_buffer_handle <= handle;
      req_query_base    <= base;
      @(posedge clock);
      // valid stays high into the next call, so back to back transfers need no gap
      while (req_stall)
         @(posedge clock);
      phase_items++;
   endtask

   task automatic run_directed();
      send_request(OP_POP, '0, '0, '0, '0);                   // pop from an empty table
      send_request(OP_QUERY, '0, '0, '0, '0);                 // empty table, base zero: -1
      send_request(OP_NONE, SEQ_MAX, SEQ_MAX, '1, SEQ_MAX);   // unused opcode, all zero reply
      send_request(OP_INSERT, SEQ_MAX, SEQ_MAX, '1, '0);      // top of the sequence range
      send_request(OP_INSERT, SEQ_W'(SEQ_MAX - 1), '0, '0, '0);   // lands in front of it
      send_request(OP_QUERY, '0, '0, '0, SEQ_W'(SEQ_MAX - 1));    // run reaches the top value
      // duplicate rewrites the tag and keeps the handle
      send_request(OP_INSERT, SEQ_MAX, 31'h2AAA_AAAA, 16'h5555, '0);
      send_request(OP_QUERY, '0, '0, '0, '0);                 // base below the front entry
      // fill to the depth in descending order, each insert goes to the front
      for (int n = 13; n >= 0; n--)
         send_request(OP_INSERT, SEQ_W'(n), TAG_W'(SEQ_MAX - n), HANDLE_W'(n), '0);
      send_request(OP_INSERT, SEQ_W'(20), SEQ_MAX, '1, '0);   // full table drops a new number
      send_request(OP_INSERT, SEQ_W'(5), 31'h5555_5555, '0, '0);  // duplicate taken when full
      send_request(OP_QUERY, '0, '0, '0, '0);                 // run from zero ends at 13
      send_request(OP_POP, '0, '0, '0, '0);
   endtask

   // packets of one window arriving out of order, with queries and pops mixed in
   task automatic run_window_stream();
      logic [SEQ_W-1:0] origin;
      int               length;
      int               pick;
      case ($urandom_range(0, 9))
         0:       origin = '0;
         1:       origin = SEQ_W'(SEQ_MAX - 19);
         default: origin = random_seq_field() >> $urandom_range(0, 30);
      endcase
      length = $urandom_range(12, 48);
      repeat (length) begin
         pick = $urandom_range(0, 99);
         // a window of 20 numbers against 16 cells gives duplicates and full drops
         if (pick < 55)
            send_request(OP_INSERT, SEQ_W'(origin + $urandom_range(0, 19)), random_seq_field(),
                         HANDLE_W'($urandom_range(0, 65535)), random_seq_field());
         else if (pick < 80)
            send_request(OP_QUERY, random_seq_field(), random_seq_field(),
                         HANDLE_W'($urandom_range(0, 65535)),
                         SEQ_W'(($urandom_range(0, 6) == 0) ? random_seq_field()
                                : origin + $urandom_range(0, 4) - 1));
         else
            send_request(OP_POP, random_seq_field(), random_seq_field(),
                         HANDLE_W'($urandom_range(0, 65535)), random_seq_field());
      end
      // half of the windows end with the table drained, the rest carry over
      if ($urandom_range(0, 1) == 0)
         repeat (TABLE_DEPTH + 1)
            send_request(OP_POP, random_seq_field(), random_seq_field(),
                         HANDLE_W'($urandom_range(0, 65535)), random_seq_field());
   endtask

   // unrelated requests with every field drawn over its whole range
   task automatic run_noise();
      repeat ($urandom_range(4, 12))
         send_request(2'($urandom_range(OP_INSERT, OP_NONE)), random_seq_field(),
                      random_seq_field(), HANDLE_W'($urandom_range(0, 65535)),
                      random_seq_field());
   endtask

   task automatic run_random_phase();
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
         if ($urandom_range(0, 3) == 0)
            run_noise();
         else
            run_window_stream();
      end
   endtask

   // response side: random stalls, plus one long hold-off that backs up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_start && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   // ends a run that stops moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // phase one: sender often idle, receiver mostly stalled
      sender_idle_pct    = 35;
      receiver_idle_pct <= 67;
      repeat (RESET_CYCLES)
         @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random_phase();
      // phase two: the other way round
      sender_idle_pct    = 67;
      receiver_idle_pct <= 35;
      run_random_phase();
      // phase three: full rate, opened by the long receiver hold-off
      sender_idle_pct    = 0;
      receiver_idle_pct <= 0;
      hold_start        <= 1'b1;
      run_random_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses != 0)
         @(posedge clock);
      // let any stray response show up before the verdict
      repeat (SETTLE_CYCLES)
         @(posedge clock);
      if (mismatch_count == 0 && pending_responses == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* sim.f */
design/ssrt_pkg.sv
design/ssrt_ctrl.sv
design/ssrt_datapath.sv
design/sorted_sequence_reorder_table.sv
design/ssrt_checker.sv
tb/sv/reorder_table_checker.sv
tb/sv/sorted_sequence_reorder_table_tb.sv
